>>> design/rpfw_pkg.sv
// ----------------------------------------------------------------------------
// rpfw_pkg
// Shared constants, codes and types of the rotated paged framebuffer pixel
// writer.
// ----------------------------------------------------------------------------
`default_nettype none

package rpfw_pkg;

  localparam int PANEL_WIDTH  = 640;
  localparam int PANEL_HEIGHT = 384;
  localparam int PAGE_BYTES   = 7680;
  localparam int BUFFER_BYTES = 30720;

  localparam int POS_W      = 11;
  localparam int ADDR_W     = 15;
  localparam int BYTE_W     = 8;
  localparam int ROT_W      = 2;
  localparam int PAGE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SEL = 1'b1;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  localparam logic [PAGE_W-1:0] PAGE_SEL_RESET = 3'b111;

  localparam int COORD_W = (PANEL_WIDTH > PANEL_HEIGHT) ? $clog2(PANEL_WIDTH)
                                                        : $clog2(PANEL_HEIGHT);
  localparam int LIM_W   = POS_W + 1;
  localparam int IDX_MAX = (PANEL_WIDTH - 1) / 8
                         + ((PANEL_HEIGHT - 1) * PANEL_WIDTH) / 8;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);
  localparam int PROD_W  = $clog2((PANEL_HEIGHT - 1) * PANEL_WIDTH + 1) + 1;
  localparam int PG_W    = $clog2(4 * PAGE_BYTES + 1);
  localparam int CMP_A   = (IDX_W > PG_W) ? IDX_W : PG_W;
  localparam int CMP_W   = ((CMP_A > ADDR_W) ? CMP_A : ADDR_W) + 1;
  localparam int RAM_AW  = $clog2(BUFFER_BYTES);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_REJECT,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
    logic              colour;
  } entry_t;

  typedef struct packed {
    logic [ROT_W-1:0]  rotation;
    logic [PAGE_W-1:0] page_select;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/rpfw_ram.sv
// ----------------------------------------------------------------------------
// rpfw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfw_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/rpfw_front.sv
// ----------------------------------------------------------------------------
// rpfw_front
// Two-stage front end: bounds check, rotation and row offset, then byte
// index, page window check and request classification.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfw_front import rpfw_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    take_i,
  input  wire logic                    kind_i,
  input  wire logic signed [POS_W-1:0] pos_x_i,
  input  wire logic signed [POS_W-1:0] pos_y_i,
  input  wire logic                    colour_nonzero_i,
  input  wire logic [ADDR_W-1:0]       read_address_i,
  input  wire cfg_t                    cfg_i,
  output logic                         push_o,
  output entry_t                       push_entry_o,
  output logic [1:0]                   inflight_o
);

  logic [LIM_W-1:0]   x_ext, y_ext, lw, lh;
  logic               inb_d;
  logic [LIM_W-1:0]   px_full, py_full;
  logic [PROD_W-1:0]  prod;

  logic               a_v_q, a_kind_q, a_inb_q, a_colour_q;
  logic [COORD_W-1:0] a_px_q;
  logic [IDX_W-1:0]   a_row_q;
  logic [ADDR_W-1:0]  a_raddr_q;

  logic [CMP_W-1:0]   idx, lo, hi, rel;
  logic               paged, ok;
  entry_t             b_d;
  logic               b_v_q;
  entry_t             b_q;

  always_comb begin
    x_ext   = LIM_W'($unsigned(pos_x_i));
    y_ext   = LIM_W'($unsigned(pos_y_i));
    lw      = cfg_i.rotation[0] ? LIM_W'(PANEL_HEIGHT) : LIM_W'(PANEL_WIDTH);
    lh      = cfg_i.rotation[0] ? LIM_W'(PANEL_WIDTH) : LIM_W'(PANEL_HEIGHT);
    inb_d   = !pos_x_i[POS_W-1] && !pos_y_i[POS_W-1] && (x_ext < lw) && (y_ext < lh);
    case (cfg_i.rotation)
      ROT_90: begin
        px_full = LIM_W'(PANEL_WIDTH - 1) - y_ext;
        py_full = x_ext;
      end
      ROT_180: begin
        px_full = LIM_W'(PANEL_WIDTH - 1) - x_ext;
        py_full = LIM_W'(PANEL_HEIGHT - 1) - y_ext;
      end
      ROT_270: begin
        px_full = y_ext;
        py_full = LIM_W'(PANEL_HEIGHT - 1) - x_ext;
      end
      default: begin
        px_full = x_ext;
        py_full = y_ext;
      end
    endcase
    prod = PROD_W'(py_full[COORD_W-1:0]) * PROD_W'(PANEL_WIDTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_kind_q   <= kind_i;
    a_inb_q    <= inb_d;
    a_colour_q <= colour_nonzero_i;
    a_px_q     <= px_full[COORD_W-1:0];
    a_row_q    <= IDX_W'(prod >> 3);
    a_raddr_q  <= read_address_i;
  end

  always_comb begin
    idx   = CMP_W'(a_px_q >> 3) + CMP_W'(a_row_q);
    paged = !cfg_i.page_select[PAGE_W-1] && (cfg_i.page_select[PAGE_W-2:0] != '0);
    lo    = CMP_W'(PAGE_BYTES) * CMP_W'(cfg_i.page_select[PAGE_W-2:0]);
    hi    = lo + CMP_W'(PAGE_BYTES);
    rel   = paged ? (idx - lo) : idx;
    ok    = a_inb_q && !(paged && ((idx < lo) || (idx >= hi)))
            && (rel < CMP_W'(BUFFER_BYTES));
    b_d.bit_sel = a_px_q[2:0];
    b_d.colour  = a_colour_q;
    if (a_kind_q) begin
      b_d.addr = a_raddr_q;
      b_d.op   = (CMP_W'(a_raddr_q) < CMP_W'(BUFFER_BYTES)) ? OP_READ : OP_REJECT;
    end else begin
      b_d.addr = ok ? ADDR_W'(rel) : '0;
      b_d.op   = ok ? OP_WRITE : OP_REJECT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
  end

  assign push_o       = b_v_q;
  assign push_entry_o = b_q;
  assign inflight_o   = 2'(a_v_q) + 2'(b_v_q);

endmodule

`default_nettype wire

>>> design/rpfw_queue.sv
// ----------------------------------------------------------------------------
// rpfw_queue
// Short request queue between the front end and the store back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfw_queue import rpfw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire entry_t            push_entry_i,
  input  wire logic              pop_i,
  output entry_t                 head_o,
  output logic [QCNT_W-1:0]      count_o
);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

>>> design/rpfw_back.sv
// ----------------------------------------------------------------------------
// rpfw_back
// Store back end: clearing pass after reset, read-modify-write of the frame
// store with forwarding of the last write, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfw_back import rpfw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire entry_t            head_i,
  input  wire logic [QCNT_W-1:0] count_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  output logic                   done_o,
  output logic                   accepted_o,
  output logic [ADDR_W-1:0]      byte_address_o,
  output logic [BYTE_W-1:0]      byte_value_o
);

  logic              clr_q;
  logic [RAM_AW-1:0] clr_cnt_q;

  logic              s1_v_q;
  entry_t            s1_q;
  logic              last_v_q;
  logic [RAM_AW-1:0] last_addr_q;
  logic [BYTE_W-1:0] last_data_q;

  logic [BYTE_W-1:0] rdata, old_byte, mask, new_byte;
  logic              s1_write;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;

  logic              res_v_q, res_acc_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic [BYTE_W-1:0] res_val_q;

  assign pop_o = (count_i != '0) && !clr_q;

  always_comb begin
    s1_write = s1_v_q && (s1_q.op == OP_WRITE);
    old_byte = (last_v_q && (last_addr_q == s1_q.addr[RAM_AW-1:0])) ? last_data_q
                                                                     : rdata;
    mask     = BYTE_W'(8'h80) >> s1_q.bit_sel;
    new_byte = s1_q.colour ? (old_byte & ~mask) : (old_byte | mask);
    ram_we    = clr_q || s1_write;
    ram_waddr = clr_q ? clr_cnt_q : s1_q.addr[RAM_AW-1:0];
    ram_wdata = clr_q ? '0 : new_byte;
  end

  rpfw_ram #(
    .Width (BYTE_W),
    .Depth (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_i.addr[RAM_AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      last_v_q  <= 1'b0;
      res_v_q   <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + RAM_AW'(1);
        if (clr_cnt_q == RAM_AW'(BUFFER_BYTES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      s1_v_q   <= pop_o;
      last_v_q <= s1_write;
      res_v_q  <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q        <= head_i;
    last_addr_q <= s1_q.addr[RAM_AW-1:0];
    last_data_q <= new_byte;
    res_addr_q  <= s1_q.addr;
    case (s1_q.op)
      OP_WRITE: begin
        res_acc_q <= 1'b1;
        res_val_q <= new_byte;
      end
      OP_READ: begin
        res_acc_q <= 1'b1;
        res_val_q <= old_byte;
      end
      default: begin
        res_acc_q <= 1'b0;
        res_val_q <= '0;
      end
    endcase
  end

  assign clearing_o     = clr_q;
  assign done_o         = res_v_q;
  assign accepted_o     = res_acc_q;
  assign byte_address_o = res_addr_q;
  assign byte_value_o   = res_val_q;

endmodule

`default_nettype wire

>>> design/rotated_paged_framebuffer_pixel_writer.sv
// ----------------------------------------------------------------------------
// rotated_paged_framebuffer_pixel_writer
// Rotated, paged 1-bit-per-pixel frame store writer and byte reader.
//
//   Channel  Handshake            Payload
//   request  start / busy         kind_i, pos_x_i, pos_y_i, colour_nonzero_i,
//                                 read_address_i
//   result   done_o (one cycle)   accepted_o, byte_address_o, byte_value_o
//   config   cfg_we_i             cfg_idx_i, cfg_data_i
//
// One request per cycle is taken while busy is low; the result strobes come
// in request order, after the two front stages, the queue, the store's
// registered read and the result register. A read-modify-write forward
// covers back-to-back hits.
// After reset a clearing pass writes zero to all 30720 store bytes, one per
// cycle; busy stays high for those cycles. busy also rises when the queue
// and front stages hold as many requests as the queue has entries.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_paged_framebuffer_pixel_writer import rpfw_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    kind_i,
  input  wire logic signed [POS_W-1:0] pos_x_i,
  input  wire logic signed [POS_W-1:0] pos_y_i,
  input  wire logic                    colour_nonzero_i,
  input  wire logic [ADDR_W-1:0]       read_address_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic                         done_o,
  output logic                         accepted_o,
  output logic [ADDR_W-1:0]            byte_address_o,
  output logic [BYTE_W-1:0]            byte_value_o
);

  cfg_t              cfg_q;
  logic              take;
  logic              push, pop, clearing;
  entry_t            push_entry, head;
  logic [1:0]        inflight;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W:0]   load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation    <= ROT_0;
      cfg_q.page_select <= PAGE_SEL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROTATION: cfg_q.rotation    <= cfg_data_i[ROT_W-1:0];
        REG_PAGE_SEL: cfg_q.page_select <= cfg_data_i[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign load = (QCNT_W + 1)'(count) + (QCNT_W + 1)'(inflight);
  assign busy = clearing || (load >= (QCNT_W + 1)'(QUEUE_DEPTH));
  assign take = start && !busy;

  rpfw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .kind_i           (kind_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .colour_nonzero_i (colour_nonzero_i),
    .read_address_i   (read_address_i),
    .cfg_i            (cfg_q),
    .push_o           (push),
    .push_entry_o     (push_entry),
    .inflight_o       (inflight)
  );

  rpfw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .count_o      (count)
  );

  rpfw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .count_i        (count),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .byte_address_o (byte_address_o),
    .byte_value_o   (byte_value_o)
  );

endmodule

`default_nettype wire
